/* rtl/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// Used by u2u_front, u2u_queue, u2u_back and utf8_to_ucs2_decoder.
package u2u_pkg;

   localparam int UNIT_W = 16;
   localparam int BYTE_W = 8;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   localparam logic [UNIT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [UNIT_W-1:0] code;
      logic              last;
   } unit_type;

endpackage

/* rtl/utf8_to_ucs2_decoder.sv */
// Top level of the UTF-8 to UCS-2 decoder: front end, unit queue, back end.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.
//
// The req channel carries one byte of a UTF-8 string per item; req_tlast
// marks the final byte of a string. The rsp channel carries one 16-bit
// unit per completed character together with the running unit count of
// the string; rsp_tlast marks the unit that ends the string. A string
// whose last character is cut short yields that partial unit at once.
// csr_we writes csr_wdata into the byte-order bit: 1 passes units as
// decoded, 0 swaps their two bytes. Write it only while the block is idle.
//
// One byte is accepted every cycle while the unit queue has room. A unit
// that a byte completes passes through the unit queue and then the output
// register before it appears on rsp. When the receiver stalls, the queue of
// QUEUE_DEPTH units and the output register absorb bytes until the queue
// is full, then req_tready drops. Reset empties the queue, clears the
// character being gathered and the unit count, and sets the byte-order
// bit to 1.
module utf8_to_ucs2_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [u2u_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] utf8_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*u2u_pkg::UNIT_W-1:0]  rsp_tdata,   // [15:0] unit_value, [31:16] unit_count
   output logic                          rsp_tlast
);

   logic              push_valid, push_ready;
   u2u_pkg::unit_type push_unit;
   logic              pop_valid, pop_ready;
   u2u_pkg::unit_type pop_unit;

   u2u_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_unit  (push_unit)
   );

   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_unit   (push_unit),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_unit  (pop_unit)
   );

   u2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_unit   (pop_unit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/u2u_front.sv */
// Front end: accepts UTF-8 bytes, tracks the character being gathered and
// pushes finished units into the queue. Depends on u2u_pkg.
module u2u_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [u2u_pkg::BYTE_W-1:0]         req_tdata,
   input  logic                               req_tlast,
   output logic                               push_valid,
   input  logic                               push_ready,
   output u2u_pkg::unit_type                  push_unit
);

   logic [1:0]                  pend_ff, pend_in;
   logic [u2u_pkg::UNIT_W-1:0]  code_ff, code_in;
   logic                        fire;
   logic                        emit;
   logic [u2u_pkg::UNIT_W-1:0]  emit_code;

   assign req_tready = push_ready;
   assign fire       = req_tvalid && push_ready;

   always_comb begin
      pend_in   = pend_ff;
      code_in   = code_ff;
      emit      = 1'b0;
      emit_code = code_ff;
      if (fire) begin
         case (pend_ff)
            u2u_pkg::PEND_NONE: begin
               if (!req_tdata[7]) begin
                  emit      = 1'b1;
                  emit_code = {9'b0, req_tdata[6:0]};
                  code_in   = '0;
               end else if (req_tdata[7:5] == 3'b110) begin
                  code_in = {5'b0, req_tdata[4:0], 6'b0};
                  pend_in = u2u_pkg::PEND_ONE;
               end else begin
                  code_in = {req_tdata[3:0], 12'b0};
                  pend_in = u2u_pkg::PEND_TWO;
               end
            end
            u2u_pkg::PEND_ONE: begin
               emit      = 1'b1;
               emit_code = code_ff | {10'b0, req_tdata[5:0]};
               code_in   = '0;
               pend_in   = u2u_pkg::PEND_NONE;
            end
            default: begin
               code_in = code_ff | {4'b0, req_tdata[5:0], 6'b0};
               pend_in = u2u_pkg::PEND_ONE;
            end
         endcase
         if (req_tlast) begin
            if (!emit) begin
               emit      = 1'b1;
               emit_code = code_in;
            end
            code_in = '0;
            pend_in = u2u_pkg::PEND_NONE;
         end
      end
   end

   assign push_valid     = emit;
   assign push_unit.code = emit_code;
   assign push_unit.last = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= u2u_pkg::PEND_NONE;
         code_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         code_ff <= code_in;
      end
   end

   // A string never ends without a unit being emitted.
   assert property (@(posedge clock) disable iff (reset)
      fire && req_tlast |-> emit)
      else $error("end of string accepted without a unit");

   // At most two following bytes are ever outstanding.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("pending byte count out of range");

endmodule

/* rtl/u2u_queue.sv */
// Short register queue of decoded units between the front and back ends.
// Depends on u2u_pkg for the unit type.
module u2u_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  u2u_pkg::unit_type in_unit,
   output logic              out_valid,
   input  logic              out_ready,
   output u2u_pkg::unit_type out_unit
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u2u_pkg::unit_type mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = cnt_ff != CW'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_unit  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // The fill count never exceeds the number of entries.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count overflow");

endmodule

/* rtl/u2u_back.sv */
// Back end: takes units from the queue, applies the byte order, keeps the
// running unit count and holds the result register. Depends on u2u_pkg.
module u2u_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_wdata,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  u2u_pkg::unit_type               pop_unit,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*u2u_pkg::UNIT_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast
);

   logic                        big_endian_ff;
   logic                        valid_ff, valid_in;
   logic [u2u_pkg::UNIT_W-1:0]  value_ff, value_in;
   logic [u2u_pkg::UNIT_W-1:0]  count_ff, count_in;
   logic                        last_ff;
   logic [u2u_pkg::UNIT_W-1:0]  done_ff, done_in;
   logic                        pop;

   assign pop_ready = !valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      valid_in = valid_ff;
      done_in  = done_ff;
      count_in = (done_ff == u2u_pkg::COUNT_MAX) ? done_ff : done_ff + 1'b1;
      value_in = big_endian_ff ? pop_unit.code
                               : {pop_unit.code[7:0], pop_unit.code[15:8]};
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
         done_in  = pop_unit.last ? '0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff <= value_in;
         count_ff <= count_in;
         last_ff  <= pop_unit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
         valid_ff      <= 1'b0;
         done_ff       <= '0;
      end else begin
         if (csr_we) begin
            big_endian_ff <= csr_wdata;
         end
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {count_ff, value_ff};
   assign rsp_tlast  = last_ff;

   // The count restarts after the unit that ends a string.
   assert property (@(posedge clock) disable iff (reset)
      pop && pop_unit.last |=> done_ff == '0)
      else $error("unit count not cleared at end of string");

   // A unit on the output always carries a count of at least one.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> count_ff != '0)
      else $error("result shown with zero unit count");

endmodule

/* dv/tb.sv */
// Self-checking testbench for utf8_to_ucs2_decoder: directed table, random UTF-8 text,
// random idling on both channels.
// Depends on u2u_pkg and the utf8_to_ucs2_decoder RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      FROM_DECODE,
      TYPED_NONE,
      TYPED_UNIT
   } check_kind_type;

   typedef struct packed {
      logic [u2u_pkg::BYTE_W-1:0] data;
      logic                       eos;
      check_kind_type             kind;
      logic [u2u_pkg::UNIT_W-1:0] value;
      logic                       last;
      logic [u2u_pkg::UNIT_W-1:0] count;
   } byte_item_type;

   typedef struct packed {
      logic [u2u_pkg::UNIT_W-1:0] value;
      logic                       last;
      logic [u2u_pkg::UNIT_W-1:0] count;
   } ucs2_unit_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic                          csr_wdata = 1'b0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [u2u_pkg::BYTE_W-1:0]    req_tdata = '0;
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [2*u2u_pkg::UNIT_W-1:0]  rsp_tdata;
   logic                          rsp_tlast;

   byte_item_type  byte_feed[$];
   ucs2_unit_type  expected_units[$];
   byte_item_type  on_bus;
   int             errors = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             hold_left = 0;
   int             seg_left = 0;
   logic           seg_ready = 1'b1;
   logic           long_hold_req = 1'b0;

   logic [1:0]                 dec_pending = u2u_pkg::PEND_NONE;
   logic [u2u_pkg::UNIT_W-1:0] dec_code = '0;
   logic [u2u_pkg::UNIT_W-1:0] dec_units = '0;
   logic                       dec_big_endian = 1'b1;

   byte_item_type directed_rows [25] = '{
      '{8'h00, 1'b1, TYPED_UNIT, 16'h0000, 1'b1, 16'd1},
      '{8'h7F, 1'b0, TYPED_UNIT, 16'h007F, 1'b0, 16'd1},
      '{8'h41, 1'b1, TYPED_UNIT, 16'h0041, 1'b1, 16'd2},
      '{8'hC3, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hA9, 1'b1, TYPED_UNIT, 16'h00E9, 1'b1, 16'd1},
      '{8'hE2, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'h82, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hAC, 1'b1, FROM_DECODE, 16'h0000, 1'b0, 16'd0},
      '{8'hDF, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hBF, 1'b0, TYPED_UNIT, 16'h07FF, 1'b0, 16'd1},
      '{8'hEF, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hBF, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hBF, 1'b1, TYPED_UNIT, 16'hFFFF, 1'b1, 16'd2},
      '{8'hC2, 1'b1, TYPED_UNIT, 16'h0080, 1'b1, 16'd1},
      '{8'hE1, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'h80, 1'b1, TYPED_UNIT, 16'h1000, 1'b1, 16'd1},
      '{8'hF5, 1'b1, TYPED_UNIT, 16'h5000, 1'b1, 16'd1},
      '{8'h80, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hFF, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'h7F, 1'b1, FROM_DECODE, 16'h0000, 1'b0, 16'd0},
      '{8'hFF, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'h00, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'hC0, 1'b1, FROM_DECODE, 16'h0000, 1'b0, 16'd0},
      '{8'hC0, 1'b0, TYPED_NONE, 16'h0000, 1'b0, 16'd0},
      '{8'h80, 1'b1, FROM_DECODE, 16'h0000, 1'b0, 16'd0}
   };

   utf8_to_ucs2_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the decoder state by one byte and returns 1 when a unit completes.
   function automatic logic decode_step(input logic [u2u_pkg::BYTE_W-1:0] b,
                                        input logic eos, output ucs2_unit_type u);
      logic                       done;
      logic [u2u_pkg::UNIT_W-1:0] code;
      done = 1'b0;
      code = '0;
      u = '0;
      case (dec_pending)
         u2u_pkg::PEND_NONE: begin
            if (!b[7]) begin
               code = {9'd0, b[6:0]};
               done = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               dec_code = {5'd0, b[4:0], 6'd0};
               dec_pending = u2u_pkg::PEND_ONE;
            end else begin
               dec_code = {b[3:0], 12'd0};
               dec_pending = u2u_pkg::PEND_TWO;
            end
         end
         u2u_pkg::PEND_ONE: begin
            code = dec_code | {10'd0, b[5:0]};
            dec_pending = u2u_pkg::PEND_NONE;
            done = 1'b1;
         end
         default: begin
            dec_code = dec_code | {4'd0, b[5:0], 6'd0};
            dec_pending = u2u_pkg::PEND_ONE;
         end
      endcase
      if (!done && eos) begin
         code = dec_code;
         done = 1'b1;
      end
      if (done) begin
         if (dec_units != u2u_pkg::COUNT_MAX) dec_units = dec_units + 1'b1;
         u.value = dec_big_endian ? code : {code[7:0], code[15:8]};
         u.last = eos;
         u.count = dec_units;
         dec_code = '0;
         if (eos) begin
            dec_pending = u2u_pkg::PEND_NONE;
            dec_units = '0;
         end
      end
      return done;
   endfunction

   always @(posedge clock) begin
      ucs2_unit_type u;
      logic          got;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            got = decode_step(on_bus.data, on_bus.eos, u);
            if (on_bus.kind == FROM_DECODE) begin
               if (got) expected_units.push_back(u);
            end else if (on_bus.kind == TYPED_UNIT) begin
               expected_units.push_back('{on_bus.value, on_bus.last, on_bus.count});
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
               on_bus = byte_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= on_bus.data;
               req_tlast <= on_bus.eos;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left = $urandom_range(0, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 79;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_ready = ($urandom_range(0, 9) < 7);
            seg_left = seg_ready ? $urandom_range(1, 30) : $urandom_range(1, 5);
         end
         seg_left--;
         rsp_tready <= seg_ready;
      end
   end

   always @(posedge clock) begin
      ucs2_unit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_units.size() == 0) begin
            if (errors < 10)
               $display("unexpected unit: value %h count %0d last %b",
                        rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
            errors++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_tdata[15:0] !== want.value || rsp_tdata[31:16] !== want.count ||
                rsp_tlast !== want.last) begin
               if (errors < 10)
                  $display("unit mismatch: expected value %h count %0d last %b, got %h %0d %b",
                           want.value, want.count, want.last,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic set_byte_order(input logic be);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= be;
      @(posedge clock);
      csr_we <= 1'b0;
      dec_big_endian = be;
   endtask

   task automatic drain();
      while (byte_feed.size() != 0 || req_tvalid || expected_units.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed characters, with stray bytes and strings cut mid-character.
   task automatic queue_random_text(input int n);
      byte_item_type              it;
      logic [u2u_pkg::BYTE_W-1:0] seq [0:2];
      int                         i, k, len, cut;
      logic                       ends;
      it = '{8'h00, 1'b0, FROM_DECODE, 16'h0000, 1'b0, 16'd0};
      i = 0;
      while (i < n) begin
         if ($urandom_range(0, 99) < 8) begin
            len = 1;
            seq[0] = 8'($urandom_range(0, 255));
         end else begin
            len = $urandom_range(1, 3);
            seq[1] = {2'b10, 6'($urandom)};
            seq[2] = {2'b10, 6'($urandom)};
            case (len)
               1: seq[0] = {1'b0, 7'($urandom)};
               2: seq[0] = {3'b110, 5'($urandom)};
               default: seq[0] = {4'b1110, 4'($urandom)};
            endcase
         end
         cut = len;
         ends = ($urandom_range(0, 9) == 0);
         if (len > 1 && $urandom_range(0, 19) == 0) begin
            cut = $urandom_range(1, len - 1);
            ends = 1'b1;
         end
         for (k = 0; k < cut; k++) begin
            it.data = seq[k];
            it.eos = ends && (k == cut - 1);
            byte_feed.push_back(it);
         end
         i += cut;
      end
      it.data = 8'($urandom_range(0, 127));
      it.eos = 1'b1;
      byte_feed.push_back(it);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_byte_order(1'b1);
      foreach (directed_rows[r]) byte_feed.push_back(directed_rows[r]);
      drain();

      set_byte_order(1'b0);
      queue_random_text(400);
      long_hold_req = 1'b1;
      drain();

      set_byte_order(1'b1);
      queue_random_text(400);
      drain();

      set_byte_order(1'($urandom_range(0, 1)));
      queue_random_text(350);
      long_hold_req = 1'b1;
      drain();

      set_byte_order(1'b1);
      queue_random_text(350);
      drain();

      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
